// File: src/sorted_array_binary_search_defines.svh
// ----------------------------------------------------------------------------
// Sorted array binary search: assertion macros
// Shared concurrent assertion forms for the search block.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_BINARY_SEARCH_DEFINES_SVH
`define SORTED_ARRAY_BINARY_SEARCH_DEFINES_SVH

// same-cycle implication
`define SABS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_array_binary_search: assertion failed");

// next-cycle implication
`define SABS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_array_binary_search: assertion failed");

`endif

// File: src/sabs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted array binary search: package
// Widths, opcodes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package sabs_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int PROBE_W = 4;
    localparam int FIELD_W = 32;
    localparam int BOUND_W = COUNT_W + 1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic write;
        logic load;
        logic issue;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic bounds_ok;
        logic hit;
        logic next_ok;
    } sts_t;

endpackage

// File: src/sabs_ram.sv
// ----------------------------------------------------------------------------
// Sorted array binary search: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sabs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/sabs_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted array binary search: controller
// Accepts words, sequences setup and one probe per cycle, ends the search.
// ----------------------------------------------------------------------------
module sabs_ctrl
    import sabs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  logic   op,
    input  sts_t   sts,
    output cmd_t   cmd,
    output logic   busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (op == OP_SEARCH))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = sts.bounds_ok ? ST_PROBE : ST_IDLE;
            end
            ST_PROBE:
            begin
                if (sts.hit || !sts.next_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.write = start && (op == OP_WRITE);
                cmd.load  = start && (op == OP_SEARCH);
            end
            ST_SETUP:
            begin
                cmd.issue  = sts.bounds_ok;
                cmd.finish = !sts.bounds_ok;
            end
            ST_PROBE:
            begin
                cmd.step   = 1'b1;
                cmd.finish = sts.hit || !sts.next_ok;
                cmd.issue  = !(sts.hit || !sts.next_ok);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: src/sabs_dp.sv
// ----------------------------------------------------------------------------
// Sorted array binary search: datapath
// Count register, search bounds, midpoint, compare and result registers.
// ----------------------------------------------------------------------------
module sabs_dp
    import sabs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic                      element_count_we,
    input  logic [COUNT_W-1:0]        element_count,
    input  logic [INDEX_W-1:0]        element_index,
    input  logic signed [FIELD_W-1:0] element_value,
    input  logic signed [FIELD_W-1:0] search_key,
    output logic                      ram_we,
    output logic [$clog2(DEPTH)-1:0]  ram_waddr,
    output logic [DATA_WIDTH-1:0]     ram_wdata,
    output logic                      ram_re,
    output logic [$clog2(DEPTH)-1:0]  ram_raddr,
    input  logic [DATA_WIDTH-1:0]     ram_rdata,
    output logic                      done,
    output logic                      found,
    output logic [INDEX_W-1:0]        position,
    output logic [PROBE_W-1:0]        probe_count
);

    localparam int AW = $clog2(DEPTH);

    logic [COUNT_W-1:0]           count_reg;
    logic signed [DATA_WIDTH-1:0] key_reg;
    logic signed [BOUND_W-1:0]    lo_reg;
    logic signed [BOUND_W-1:0]    hi_reg;
    logic [COUNT_W-1:0]           mid_reg;
    logic [PROBE_W-1:0]           probes_reg;
    logic                         done_reg;
    logic                         found_reg;
    logic [INDEX_W-1:0]           position_reg;
    logic [PROBE_W-1:0]           probe_count_reg;

    logic [COUNT_W-1:0]           count_eff;
    logic signed [BOUND_W:0]      sum_cur;
    logic signed [BOUND_W:0]      sum_n;
    logic [COUNT_W-1:0]           mid_cur;
    logic [COUNT_W-1:0]           mid_n;
    logic [COUNT_W-1:0]           addr_mid;
    logic signed [BOUND_W-1:0]    mid_ext;
    logic signed [BOUND_W-1:0]    lo_n;
    logic signed [BOUND_W-1:0]    hi_n;
    logic signed [DATA_WIDTH-1:0] probe_val;
    logic                         lt;
    logic                         eq;
    logic                         in_range;

    assign count_eff = (32'(count_reg) > DEPTH) ? COUNT_W'(DEPTH) : count_reg;
    assign in_range  = (32'(element_index) < DEPTH);

    // current and next midpoints, bounds stay non-negative while probing
    assign sum_cur   = {lo_reg[BOUND_W-1], lo_reg} + {hi_reg[BOUND_W-1], hi_reg};
    assign mid_cur   = sum_cur[COUNT_W:1];

    assign probe_val = $signed(ram_rdata);
    assign eq        = (probe_val == key_reg);
    assign lt        = (probe_val < key_reg);

    assign mid_ext   = $signed({1'b0, mid_reg});
    assign lo_n      = lt ? (mid_ext + BOUND_W'(1)) : lo_reg;
    assign hi_n      = lt ? hi_reg : (mid_ext - BOUND_W'(1));
    assign sum_n     = {lo_n[BOUND_W-1], lo_n} + {hi_n[BOUND_W-1], hi_n};
    assign mid_n     = sum_n[COUNT_W:1];
    assign addr_mid  = cmd.step ? mid_n : mid_cur;

    assign sts.bounds_ok = (lo_reg <= hi_reg);
    assign sts.hit       = eq;
    assign sts.next_ok   = (lo_n <= hi_n);

    assign ram_we    = cmd.write && in_range;
    assign ram_waddr = AW'(element_index);
    assign ram_wdata = DATA_WIDTH'(element_value);
    assign ram_re    = cmd.issue;
    assign ram_raddr = AW'(addr_mid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (element_count_we)
            begin
                count_reg <= element_count;
            end
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= DATA_WIDTH'(search_key);
            lo_reg     <= '0;
            hi_reg     <= $signed({1'b0, count_eff}) - BOUND_W'(1);
            probes_reg <= '0;
        end
        if (cmd.step)
        begin
            lo_reg     <= lo_n;
            hi_reg     <= hi_n;
            probes_reg <= probes_reg + PROBE_W'(1);
        end
        if (cmd.issue)
        begin
            mid_reg <= addr_mid;
        end
        if (cmd.finish)
        begin
            found_reg       <= cmd.step && eq;
            position_reg    <= (cmd.step && eq) ? mid_reg[INDEX_W-1:0] : '0;
            probe_count_reg <= probes_reg + PROBE_W'(cmd.step);
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign probe_count = probe_count_reg;

endmodule

// File: src/sorted_array_binary_search.sv
// Search: accept, SETUP, 0..11 probes, then the result strobe; busy until the strobe.
// Next word is accepted in the strobe cycle.
// Write words are taken while idle and give no result. One RAM read port, one probe a cycle.
// Reset (rst_n, async low) clears element_count and the controller; store is not cleared.
// Results cannot be stalled: done is high for exactly one cycle per search.
// ----------------------------------------------------------------------------
// Sorted array binary search: top level
// Sorted element store with iterative binary search over element_count words, at most DEPTH.
// ----------------------------------------------------------------------------
`include "sorted_array_binary_search_defines.svh"

module sorted_array_binary_search
    import sabs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      element_count_we,
    input  logic [COUNT_W-1:0]        element_count,
    input  logic                      start,
    output logic                      busy,
    input  logic                      op,
    input  logic [INDEX_W-1:0]        element_index,
    input  logic signed [FIELD_W-1:0] element_value,
    input  logic signed [FIELD_W-1:0] search_key,
    output logic                      done,
    output logic                      found,
    output logic [INDEX_W-1:0]        position,
    output logic [PROBE_W-1:0]        probe_count
);

    localparam int AW = $clog2(DEPTH);

    cmd_t                  cmd;
    sts_t                  sts;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    sabs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    sabs_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .element_count_we (element_count_we),
        .element_count    (element_count),
        .element_index    (element_index),
        .element_value    (element_value),
        .search_key       (search_key),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata),
        .done             (done),
        .found            (found),
        .position         (position),
        .probe_count      (probe_count)
    );

    sabs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `SABS_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `SABS_ASSERT_NEXT(a_search_busy, clk, rst_n, start && !busy && (op == OP_SEARCH), busy)
    `SABS_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `SABS_ASSERT_NOW(a_found_probed, clk, rst_n, done && found, probe_count != '0)

endmodule
